// File: sv/ppg_pkg.sv
// Shared types and constants of the plasma pattern pixel generator.
`default_nettype none

package ppg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WAVE_AMPLITUDE = 3'd0,
    REG_WAVE_FREQUENCY = 3'd1,
    REG_RED_RATE       = 3'd2,
    REG_GREEN_RATE     = 3'd3,
    REG_BLUE_RATE      = 3'd4,
    REG_RED_PHASE      = 3'd5,
    REG_GREEN_PHASE    = 3'd6,
    REG_BLUE_PHASE     = 3'd7
  } cfg_reg_t;

  // Wave settings that every lane reads.
  typedef struct packed {
    logic signed [10:0] amplitude;
    logic signed [7:0]  frequency;
  } wave_cfg_t;

  localparam int unsigned LaneStages = 7;

  // Angle shift that makes every truncated angle non-negative (128 * 360).
  localparam logic signed [25:0] ANGLE_BIAS = 26'sd46080;
  // ceil(2^25 / 360): exact floor(v / 360) for v below 2^17.
  localparam logic [16:0] RECIP_360 = 17'd93207;
  localparam int unsigned RecipShift = 25;

  // Quarter-wave degree sine, scaled by 16384.
  localparam logic [14:0] QUARTER_SINE [0:90] = '{
    15'd0,     15'd285,   15'd571,   15'd857,   15'd1142,  15'd1427,  15'd1712,
    15'd1996,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3685,
    15'd3963,  15'd4240,  15'd4516,  15'd4790,  15'd5062,  15'd5334,  15'd5603,
    15'd5871,  15'd6137,  15'd6401,  15'd6663,  15'd6924,  15'd7182,  15'd7438,
    15'd7691,  15'd7943,  15'd8191,  15'd8438,  15'd8682,  15'd8923,  15'd9161,
    15'd9397,  15'd9630,  15'd9860,  15'd10086, 15'd10310, 15'd10531, 15'd10748,
    15'd10963, 15'd11173, 15'd11381, 15'd11585, 15'd11785, 15'd11982, 15'd12175,
    15'd12365, 15'd12550, 15'd12732, 15'd12910, 15'd13084, 15'd13254, 15'd13420,
    15'd13582, 15'd13740, 15'd13894, 15'd14043, 15'd14188, 15'd14329, 15'd14466,
    15'd14598, 15'd14725, 15'd14848, 15'd14967, 15'd15081, 15'd15190, 15'd15295,
    15'd15395, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15825, 15'd15897,
    15'd15964, 15'd16025, 15'd16082, 15'd16135, 15'd16182, 15'd16224, 15'd16261,
    15'd16294, 15'd16321, 15'd16344, 15'd16361, 15'd16374, 15'd16381, 15'd16384
  };

endpackage

`default_nettype wire

// File: sv/ppg_wave_lane.sv
// Seven-stage pipelined wave function: wave index in, 8-bit wave value out.
`default_nettype none

module ppg_wave_lane (
  input  wire logic                                 clk,
  input  wire logic [ppg_pkg::LaneStages-1:0]       en,
  input  wire ppg_pkg::wave_cfg_t                   cfg,
  input  wire logic [7:0]                           idx,
  output logic [7:0]                                w
);

  localparam int unsigned RecipShiftTop = ppg_pkg::RecipShift + 7;

  logic signed [16:0] m;
  logic [16:0]        v1;
  logic [16:0]        v2;
  logic [7:0]         q;
  logic [6:0]         tix;
  logic               neg;
  logic signed [15:0] s;
  logic signed [26:0] prod;

  logic signed [16:0] m_next;
  logic signed [25:0] mx, t, ad, ang, vo;
  logic [33:0]        qp;
  logic [16:0]        q360, r;
  logic [8:0]         a;
  logic [6:0]         tix_next;
  logic               neg_next;
  logic signed [15:0] mag, s_next;
  logic signed [26:0] prod_next, pa, sh;

  always_comb begin
    // Stage 0: index times frequency.
    m_next = $signed({1'b0, idx}) * cfg.frequency;

    // Stage 1: times 360, divide by 256 toward zero, bias above zero.
    mx  = 26'(m);
    t   = (mx <<< 8) + (mx <<< 6) + (mx <<< 5) + (mx <<< 3);
    ad  = t + (t[25] ? 26'sd255 : 26'sd0);
    ang = ad >>> 8;
    vo  = ang + ppg_pkg::ANGLE_BIAS;

    // Stage 2: quotient by 360 through the reciprocal.
    qp = 34'(v1) * 34'(ppg_pkg::RECIP_360);

    // Stage 3: remainder and quadrant fold.
    q360 = 17'({q, 8'b0}) + 17'({q, 6'b0}) + 17'({q, 5'b0}) + 17'({q, 3'b0});
    r    = v2 - q360;
    if (r >= 17'd360) begin
      r = r - 17'd360;
    end
    a = r[8:0];
    if (a <= 9'd90) begin
      tix_next = a[6:0];
      neg_next = 1'b0;
    end else if (a <= 9'd180) begin
      tix_next = 7'(9'd180 - a);
      neg_next = 1'b0;
    end else if (a <= 9'd270) begin
      tix_next = 7'(a - 9'd180);
      neg_next = 1'b1;
    end else begin
      tix_next = 7'(9'd360 - a);
      neg_next = 1'b1;
    end

    // Stage 4: table lookup.
    mag    = $signed(16'(ppg_pkg::QUARTER_SINE[tix]));
    s_next = neg ? -mag : mag;

    // Stage 5: amplitude scale.
    prod_next = cfg.amplitude * s;

    // Stage 6: divide by 16384 toward zero, keep the low byte.
    pa = prod + (prod[26] ? 27'sd16383 : 27'sd0);
    sh = pa >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m <= m_next;
    end
    if (en[1]) begin
      v1 <= vo[16:0];
    end
    if (en[2]) begin
      q  <= qp[RecipShiftTop:ppg_pkg::RecipShift];
      v2 <= v1;
    end
    if (en[3]) begin
      tix <= tix_next;
      neg <= neg_next;
    end
    if (en[4]) begin
      s <= s_next;
    end
    if (en[5]) begin
      prod <= prod_next;
    end
    if (en[6]) begin
      w <= sh[7:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/plasma_pattern_pixel_generator_top.sv
// Top level of the sine plasma pixel generator: config registers, frame state, pipeline.
//
//   port group   dir  word                                         accepted when
//   s_*          in   tdata {pixel_y, pixel_x}, tlast frame_end   s_tvalid & s_tready
//   m_*          out  tdata {blue, green, red}                     m_tvalid & m_tready
//   cfg_*        in   cfg_index register, cfg_data value           cfg_valid & cfg_ready
//
// One pixel enters per cycle unless the output stalls; each pixel crosses 8 register
// stages before m_tvalid rises. Seven stages are the wave lanes (multiply, angle scale,
// reciprocal divide by 360, quadrant fold, sine table, amplitude multiply, divide);
// the eighth sums and colors.
// Every stage holds its own valid bit and moves when the stage after it is empty or moving,
// so bubbles close up under a stalled output and nothing is dropped or repeated.
// Reset clears the valid bits and frame state and loads the config defaults; cfg_ready is always high.
`default_nettype none

module plasma_pattern_pixel_generator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int unsigned NumStages = ppg_pkg::LaneStages + 1;

  logic signed [10:0] wave_amplitude;
  logic signed [7:0]  wave_frequency;
  logic [1:0]         red_rate, green_rate, blue_rate;
  logic [7:0]         red_phase, green_phase, blue_phase;

  logic [7:0] row_offset_a, row_offset_b, col_offset_a, col_offset_b, frame_count;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;

  logic [2:0][7:0] base_pipe [0:ppg_pkg::LaneStages-1];
  logic [2:0][7:0] base_next;
  logic [3:0][7:0] lane_idx;
  logic [3:0][7:0] lane_w;
  logic [7:0]      z;
  logic [23:0]     rgb_next;

  ppg_pkg::wave_cfg_t wave_cfg;

  logic [9:0] pixel_x, pixel_y;
  logic       accept;

  function automatic logic [7:0] fold(input logic [7:0] base, input logic [7:0] zv);
    logic [7:0] c;
    logic [8:0] d;
    logic [8:0] f;
    c = base + zv;
    d = {c, 1'b0};
    f = 9'd510 - d;
    return (d > 9'd255) ? f[7:0] : d[7:0];
  endfunction

  assign pixel_x   = s_tdata[9:0];
  assign pixel_y   = s_tdata[19:10];
  assign cfg_ready = 1'b1;
  assign s_tready  = en[0];
  assign m_tvalid  = vld[NumStages-1];
  assign accept    = s_tvalid && s_tready;

  assign wave_cfg.amplitude = wave_amplitude;
  assign wave_cfg.frequency = wave_frequency;

  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || m_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // Wave indexes wrap at 256, so only the low coordinate bits matter.
  always_comb begin
    lane_idx[0] = row_offset_a + {pixel_y[6:0], 1'b0};
    lane_idx[1] = row_offset_b + pixel_y[7:0];
    lane_idx[2] = col_offset_a + pixel_x[7:0];
    lane_idx[3] = col_offset_b + {pixel_x[6:0], 1'b0};
  end

  // The color base is fixed at acceptance so a later frame step cannot reach it.
  always_comb begin
    logic [9:0] pr, pg, pb;
    pr = 10'(frame_count) * 10'(red_rate);
    pg = 10'(frame_count) * 10'(green_rate);
    pb = 10'(frame_count) * 10'(blue_rate);
    base_next[0] = pr[7:0] + red_phase;
    base_next[1] = pg[7:0] + green_phase;
    base_next[2] = pb[7:0] + blue_phase;
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    ppg_wave_lane u_lane (
      .clk (clk),
      .en  (en[ppg_pkg::LaneStages-1:0]),
      .cfg (wave_cfg),
      .idx (lane_idx[g]),
      .w   (lane_w[g])
    );
  end

  always_comb begin
    z = lane_w[0] + lane_w[1] + lane_w[2] + lane_w[3];
    rgb_next[7:0]   = fold(base_pipe[ppg_pkg::LaneStages-1][0], z);
    rgb_next[15:8]  = fold(base_pipe[ppg_pkg::LaneStages-1][1], z);
    rgb_next[23:16] = fold(base_pipe[ppg_pkg::LaneStages-1][2], z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base_pipe[0] <= base_next;
    end
    for (int k = 1; k < ppg_pkg::LaneStages; k++) begin
      if (en[k]) begin
        base_pipe[k] <= base_pipe[k-1];
      end
    end
    if (en[NumStages-1]) begin
      m_tdata <= rgb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_offset_a <= '0;
      row_offset_b <= '0;
      col_offset_a <= '0;
      col_offset_b <= '0;
      frame_count  <= '0;
    end else if (accept && s_tlast) begin
      row_offset_a <= row_offset_a + 8'd4;
      row_offset_b <= row_offset_b - 8'd2;
      col_offset_a <= col_offset_a + 8'd4;
      col_offset_b <= col_offset_b - 8'd2;
      frame_count  <= frame_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_amplitude <= 11'sd90;
      wave_frequency <= 8'sd1;
      red_rate       <= 2'd1;
      green_rate     <= 2'd2;
      blue_rate      <= 2'd3;
      red_phase      <= 8'd0;
      green_phase    <= 8'd50;
      blue_phase     <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppg_pkg::REG_WAVE_AMPLITUDE: wave_amplitude <= cfg_data;
        ppg_pkg::REG_WAVE_FREQUENCY: wave_frequency <= cfg_data[7:0];
        ppg_pkg::REG_RED_RATE:       red_rate       <= cfg_data[1:0];
        ppg_pkg::REG_GREEN_RATE:     green_rate     <= cfg_data[1:0];
        ppg_pkg::REG_BLUE_RATE:      blue_rate      <= cfg_data[1:0];
        ppg_pkg::REG_RED_PHASE:      red_phase      <= cfg_data[7:0];
        ppg_pkg::REG_GREEN_PHASE:    green_phase    <= cfg_data[7:0];
        ppg_pkg::REG_BLUE_PHASE:     blue_phase     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The row and column offsets are all tied to the frame count.
  a_offsets_track_frame: assert property (@(posedge clk) disable iff (rst)
    (row_offset_a == {frame_count[5:0], 2'b00}) && (col_offset_a == row_offset_a) &&
    (row_offset_b == col_offset_b) && (8'(row_offset_b + {frame_count[6:0], 1'b0}) == 8'd0))
    else $error("frame offsets out of step with frame count");

  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (frame_count == 8'($past(frame_count) + 8'd1)))
    else $error("frame count did not advance on the last word of a frame");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  a_output_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[NumStages-2]))
    else $error("output word appeared without one in the last lane stage");

endmodule

`default_nettype wire
